// ===== rtl/tkmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkmh_pkg
// Shared constants, types and helpers of the top-k min-heap core.
// ----------------------------------------------------------------------------
package tkmh_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int IDX_W       = $clog2(HEAP_DEPTH);
    localparam int KID_W       = IDX_W + 2;
    localparam int CNT_W       = 7;
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 104;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] REQ_OFFER = 2'd0;
    localparam logic [1:0] REQ_DUMP  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [3:0] DP_NOP       = 4'd0;
    localparam logic [3:0] DP_LOAD      = 4'd1;
    localparam logic [3:0] DP_UP_RD     = 4'd2;
    localparam logic [3:0] DP_UP_STEP   = 4'd3;
    localparam logic [3:0] DP_DN_RD     = 4'd4;
    localparam logic [3:0] DP_DN_STEP   = 4'd5;
    localparam logic [3:0] DP_PUT_CARRY = 4'd6;
    localparam logic [3:0] DP_DUMP_RD   = 4'd7;
    localparam logic [3:0] DP_CLEAR     = 4'd8;

    typedef struct packed {
        logic [DATA_W-1:0] score;
        logic [DATA_W-1:0] id;
    } t_entry;

    typedef struct packed {
        logic [3:0] op;
        logic       inc_cnt;
        logic       emit;
        logic       entry;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic push_ok;
        logic beat;
        logic pos_zero;
        logic par_zero;
        logic up_move;
        logic dn_kids;
        logic dn_move;
        logic dn_more;
        logic cnt_zero;
        logic dump_last;
    } t_dp_stat;

    typedef struct packed {
        logic [DATA_W-1:0] min_score;
        logic              is_full;
        logic [CNT_W-1:0]  held_count;
        logic [DATA_W-1:0] entry_score;
        logic [DATA_W-1:0] entry_id;
        logic              entry_valid;
        logic              last;
    } t_result;

    // A heap size of zero acts as one, and one above the depth acts as the depth.
    function automatic logic [CNT_W-1:0] eff_k(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] r;
        r = k;
        if (k == '0) begin
            r = CNT_W'(1);
        end else if (k > CNT_W'(HEAP_DEPTH)) begin
            r = CNT_W'(HEAP_DEPTH);
        end
        return r;
    endfunction

endpackage

// ===== rtl/tkmh_dp.sv =====
// ----------------------------------------------------------------------------
// tkmh_dp
// Heap datapath: entry memory, hole position, carried entry, fill count and
// heap size register, root score copy and result assembly.
// ----------------------------------------------------------------------------
module tkmh_dp import tkmh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_item_id,
    input  logic [DATA_W-1:0] i_item_score,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_k,
    output t_dp_stat          o_stat,
    output t_result           o_result,
    output logic [CNT_W-1:0]  o_heap_size
);

    t_entry            r_mem [HEAP_DEPTH];
    t_entry            r_rd_a;
    t_entry            r_rd_b;
    t_entry            r_carry;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_heap_size;
    logic [DATA_W-1:0] r_root;
    logic [IDX_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_dump_idx;

    logic [CNT_W-1:0]  k_eff;
    logic [CNT_W-1:0]  k_new;
    logic [IDX_W-1:0]  par;
    logic [IDX_W-1:0]  gpar;
    logic [KID_W-1:0]  kid_l;
    logic [KID_W-1:0]  kid_r;
    logic [KID_W-1:0]  gkid_l;
    logic [KID_W-1:0]  gkid_r;
    logic [KID_W-1:0]  cnt_ext;
    logic              take_right;
    t_entry            sel;
    logic [IDX_W-1:0]  sel_idx;

    logic              we;
    logic [IDX_W-1:0]  wa;
    t_entry            wd;
    logic              ren_a;
    logic              ren_b;
    logic [IDX_W-1:0]  ra;
    logic [IDX_W-1:0]  rb;

    always_comb begin
        k_eff      = eff_k(r_heap_size);
        k_new      = eff_k(i_cfg_k);
        cnt_ext    = KID_W'(r_count);
        par        = (r_pos - IDX_W'(1)) >> 1;
        gpar       = (par - IDX_W'(1)) >> 1;
        kid_l      = {1'b0, r_pos, 1'b1};
        kid_r      = kid_l + KID_W'(1);
        take_right = (kid_r < cnt_ext) && (r_rd_b.score < r_rd_a.score);
        sel        = take_right ? r_rd_b : r_rd_a;
        sel_idx    = take_right ? kid_r[IDX_W-1:0] : kid_l[IDX_W-1:0];
        gkid_l     = {1'b0, sel_idx, 1'b1};
        gkid_r     = gkid_l + KID_W'(1);
    end

    always_comb begin
        o_stat.push_ok   = r_count < k_eff;
        o_stat.beat      = r_carry.score > r_root;
        o_stat.pos_zero  = r_pos == '0;
        o_stat.par_zero  = par == '0;
        o_stat.up_move   = r_carry.score < r_rd_a.score;
        o_stat.dn_kids   = kid_l < cnt_ext;
        o_stat.dn_move   = sel.score < r_carry.score;
        o_stat.dn_more   = gkid_l < cnt_ext;
        o_stat.cnt_zero  = r_count == '0;
        o_stat.dump_last = r_dump_idx == r_count;
    end

    always_comb begin
        we    = 1'b0;
        wa    = r_pos;
        wd    = r_carry;
        ren_a = 1'b0;
        ren_b = 1'b0;
        ra    = par;
        rb    = kid_r[IDX_W-1:0];
        unique case (i_cmd.op)
            DP_UP_RD: begin
                ren_a = 1'b1;
            end
            DP_UP_STEP: begin
                we    = 1'b1;
                wd    = r_rd_a;
                ren_a = 1'b1;
                ra    = gpar;
            end
            DP_DN_RD: begin
                ren_a = 1'b1;
                ren_b = 1'b1;
                ra    = kid_l[IDX_W-1:0];
            end
            DP_DN_STEP: begin
                we    = 1'b1;
                wd    = sel;
                ren_a = 1'b1;
                ren_b = 1'b1;
                ra    = gkid_l[IDX_W-1:0];
                rb    = gkid_r[IDX_W-1:0];
            end
            DP_PUT_CARRY: begin
                we = 1'b1;
            end
            DP_DUMP_RD: begin
                ren_a = 1'b1;
                ra    = r_dump_idx[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (ren_a) begin
            r_rd_a <= r_mem[ra];
        end
        if (ren_b) begin
            r_rd_b <= r_mem[rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && (wa == '0)) begin
            r_root <= wd.score;
        end
        case (i_cmd.op)
            DP_LOAD: begin
                r_carry.id    <= i_item_id;
                r_carry.score <= i_item_score;
                r_pos         <= o_stat.push_ok ? r_count[IDX_W-1:0] : '0;
                r_dump_idx    <= '0;
            end
            DP_UP_STEP: begin
                r_pos <= par;
            end
            DP_DN_STEP: begin
                r_pos <= sel_idx;
            end
            DP_DUMP_RD: begin
                r_dump_idx <= r_dump_idx + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_heap_size <= CNT_W'(HEAP_DEPTH);
        end else if (i_cfg_we) begin
            r_heap_size <= i_cfg_k;
            if (r_count > k_new) begin
                r_count <= k_new;
            end
        end else if (i_cmd.op == DP_CLEAR) begin
            r_count <= '0;
        end else if (i_cmd.inc_cnt) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_comb begin
        o_result.entry_valid = i_cmd.entry;
        o_result.entry_id    = i_cmd.entry ? r_rd_a.id : '0;
        o_result.entry_score = i_cmd.entry ? r_rd_a.score : '0;
        o_result.held_count  = r_count;
        o_result.is_full     = r_count == k_eff;
        o_result.min_score   = (r_count != '0) ? r_root : '0;
        o_result.last        = i_cmd.last;
    end

    assign o_heap_size = r_heap_size;

endmodule

// ===== rtl/tkmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkmh_ctrl
// Request sequencer: decodes a request and steps the datapath through the
// sift-up, sift-down or dump walk, then hands out the results.
// ----------------------------------------------------------------------------
module tkmh_ctrl import tkmh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_req,
    input  logic       i_out_free,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_UP_FIN   = 4'd3;
    localparam logic [3:0] S_DN_CMP   = 4'd4;
    localparam logic [3:0] S_DN_FIN   = 4'd5;
    localparam logic [3:0] S_DUMP_RD  = 4'd6;
    localparam logic [3:0] S_DUMP_OUT = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_req;
    logic [1:0] n_req;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_req    = i_in_req;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
                unique case (r_req)
                    REQ_OFFER: begin
                        if (i_stat.push_ok) begin
                            if (i_stat.pos_zero) begin
                                o_cmd.op      = DP_PUT_CARRY;
                                o_cmd.inc_cnt = 1'b1;
                            end else begin
                                o_cmd.op = DP_UP_RD;
                                n_state  = S_UP_CMP;
                            end
                        end else if (i_stat.beat) begin
                            if (i_stat.dn_kids) begin
                                o_cmd.op = DP_DN_RD;
                                n_state  = S_DN_CMP;
                            end else begin
                                o_cmd.op = DP_PUT_CARRY;
                            end
                        end
                    end
                    REQ_DUMP: begin
                        if (!i_stat.cnt_zero) begin
                            o_cmd.op = DP_DUMP_RD;
                            n_state  = S_DUMP_OUT;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.op = DP_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            S_UP_CMP: begin
                if (i_stat.up_move) begin
                    o_cmd.op = DP_UP_STEP;
                    n_state  = i_stat.par_zero ? S_UP_FIN : S_UP_CMP;
                end else begin
                    o_cmd.op      = DP_PUT_CARRY;
                    o_cmd.inc_cnt = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_UP_FIN: begin
                o_cmd.op      = DP_PUT_CARRY;
                o_cmd.inc_cnt = 1'b1;
                n_state       = S_EMIT;
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    o_cmd.op = DP_DN_STEP;
                    n_state  = i_stat.dn_more ? S_DN_CMP : S_DN_FIN;
                end else begin
                    o_cmd.op = DP_PUT_CARRY;
                    n_state  = S_EMIT;
                end
            end
            S_DN_FIN: begin
                o_cmd.op = DP_PUT_CARRY;
                n_state  = S_EMIT;
            end
            S_DUMP_RD: begin
                o_cmd.op = DP_DUMP_RD;
                n_state  = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.entry = 1'b1;
                    o_cmd.last  = i_stat.dump_last;
                    n_state     = i_stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_OFFER;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

endmodule

// ===== rtl/top_k_min_heap_core.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_core
// Keeps the k highest-scoring (id, score) pairs in a binary min-heap.
//
//  Channel   Dir  Fields
//  s_axis    in   tuser: req_type; tdata: item_id, item_score
//  m_axis    out  tuser: entry_valid; tlast: last; tdata: entry_id,
//                 entry_score, held_count, is_full, min_score
//  APB       in   register 0 at byte address 0: heap_size
//
// One request is in work at a time. An offer moves the carried entry one heap
// level per step, set by the single write port of the heap memory.
// A dump sends out its held entries one at a time; a clear or other request one status result.
// Reset is synchronous and needs no clearing pass; the heap reads as empty.
// A result waits in the output register, and the core stalls only when a
// further result is due while that register is still full.
// ----------------------------------------------------------------------------
module top_k_min_heap_core import tkmh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // item_id [31:0], item_score [63:32]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // entry_id [31:0], entry_score [63:32], held_count [70:64],
    // is_full [71], min_score [103:72]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // entry_valid [0]
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_result          result;
    logic [CNT_W-1:0] heap_size;
    logic             cfg_we;
    logic             out_free;

    t_result          r_out;
    logic             r_out_valid;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? '0 : PDATA_W'(heap_size);
    assign out_free = !r_out_valid || m_axis_tready;

    tkmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_req   (s_axis_tuser),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tkmh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item_id    (s_axis_tdata[DATA_W-1:0]),
        .i_item_score (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_cfg_we     (cfg_we),
        .i_cfg_k      (pwdata[CNT_W-1:0]),
        .o_stat       (stat),
        .o_result     (result),
        .o_heap_size  (heap_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.min_score, r_out.is_full, r_out.held_count,
                            r_out.entry_score, r_out.entry_id};
    assign m_axis_tuser  = r_out.entry_valid;
    assign m_axis_tlast  = r_out.last;

endmodule

// ===== rtl/tkmh_checker.sv =====
// ----------------------------------------------------------------------------
// tkmh_checker
// Port-level checks of the top-k min-heap core, bound to its top level.
// ----------------------------------------------------------------------------
module tkmh_checker import tkmh_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transfer dropped or changed while stalled");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == '0 && m_axis_tlast)
        else $error("status result carries entry data or is not last");

    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[70:64] == '0
        |-> m_axis_tdata[103:72] == '0 && !m_axis_tuser)
        else $error("empty heap shows a minimum score or an entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'(HEAP_DEPTH))
        else $error("held count above heap depth");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("core not idle after reset");

endmodule

bind top_k_min_heap_core tkmh_checker u_tkmh_checker (.*);

// ===== tb/top_k_min_heap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_min_heap_checker
// Watches the request, result and register channels of the top-k heap core.
// It keeps its own copy of the heap and the heap size, works out the results
// of each accepted request and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module top_k_min_heap_checker
    import tkmh_pkg::*;
#(
    parameter logic [PADDR_W-1:0] P_HEAP_SIZE_ADDR = '0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [1:0]             i_s_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                   i_m_axis_tuser,
    input  logic                   i_m_axis_tlast,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    input  logic [PDATA_W-1:0]     i_prdata,
    input  logic                   i_pready,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [DATA_W-1:0] heap_id [HEAP_DEPTH];
    logic [DATA_W-1:0] heap_score [HEAP_DEPTH];
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  k_raw;
    t_result           due_q [$];
    t_result           want;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [CNT_W-1:0] kept_limit(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] lim;
        lim = raw;
        if (raw == '0) begin
            lim = CNT_W'(1);
        end else if (raw > CNT_W'(HEAP_DEPTH)) begin
            lim = CNT_W'(HEAP_DEPTH);
        end
        return lim;
    endfunction

    task automatic flag(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] exp_v);
        if (fail_count < 50) begin
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, exp_v,
                     $time);
        end
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] exp_v);
        if (got !== exp_v) begin
            flag(what, got, exp_v);
        end
    endtask

    task automatic push_status(input logic [DATA_W-1:0] id, input logic [DATA_W-1:0] sc,
                               input logic valid, input logic fin);
        t_result r;
        r.entry_id    = id;
        r.entry_score = sc;
        r.entry_valid = valid;
        r.held_count  = held;
        r.is_full     = (held == kept_limit(k_raw));
        r.min_score   = (held != '0) ? heap_score[0] : '0;
        r.last        = fin;
        due_q.push_back(r);
    endtask

    task automatic apply_request(input logic [1:0] req, input logic [DATA_W-1:0] id,
                                 input logic [DATA_W-1:0] sc);
        int               pos;
        int               par;
        int               c;
        int               n;
        logic [CNT_W-1:0] k;
        k = kept_limit(k_raw);
        case (req)
            REQ_OFFER: begin
                if (held < k) begin
                    pos = int'(held);
                    while (pos > 0) begin
                        par = (pos - 1) / 2;
                        if (!(sc < heap_score[par])) break;
                        heap_id[pos]    = heap_id[par];
                        heap_score[pos] = heap_score[par];
                        pos = par;
                    end
                    heap_id[pos]    = id;
                    heap_score[pos] = sc;
                    held = held + 1'b1;
                end else if (held != '0 && sc > heap_score[0]) begin
                    n   = int'(held);
                    pos = 0;
                    while (pos * 2 + 1 < n) begin
                        c = pos * 2 + 1;
                        if (c + 1 < n && heap_score[c + 1] < heap_score[c]) c++;
                        if (heap_score[c] >= sc) break;
                        heap_id[pos]    = heap_id[c];
                        heap_score[pos] = heap_score[c];
                        pos = c;
                    end
                    heap_id[pos]    = id;
                    heap_score[pos] = sc;
                end
                push_status('0, '0, 1'b0, 1'b1);
            end
            REQ_DUMP: begin
                if (held == '0) begin
                    push_status('0, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < int'(held); i++) begin
                        push_status(heap_id[i], heap_score[i], 1'b1, i == int'(held) - 1);
                    end
                end
            end
            REQ_CLEAR: begin
                held = '0;
                push_status('0, '0, 1'b0, 1'b1);
            end
            default: begin
                push_status('0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result();
        if (due_q.size() == 0) begin
            flag("result transfer with nothing expected", i_m_axis_tdata[31:0], '0);
        end else begin
            want = due_q.pop_front();
            check_field("entry_id", i_m_axis_tdata[31:0], want.entry_id);
            check_field("entry_score", i_m_axis_tdata[63:32], want.entry_score);
            check_field("held_count", 32'(i_m_axis_tdata[70:64]), 32'(want.held_count));
            check_field("is_full", 32'(i_m_axis_tdata[71]), 32'(want.is_full));
            check_field("min_score", i_m_axis_tdata[103:72], want.min_score);
            check_field("entry_valid", 32'(i_m_axis_tuser), 32'(want.entry_valid));
            check_field("last", 32'(i_m_axis_tlast), 32'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held  = '0;
            k_raw = CNT_W'(HEAP_DEPTH);
            due_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == P_HEAP_SIZE_ADDR) begin
                if (i_pwrite) begin
                    k_raw = i_pwdata[CNT_W-1:0];
                    if (held > kept_limit(k_raw)) held = kept_limit(k_raw);
                end else begin
                    check_field("heap_size readback", i_prdata, 32'(k_raw));
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_request(i_s_axis_tuser, i_s_axis_tdata[31:0], i_s_axis_tdata[63:32]);
            end
        end
        o_pending = due_q.size();
    end

endmodule

// ===== tb/top_k_min_heap_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_min_heap_core_tb
// Drives requests and heap size writes into the top-k heap core: a directed
// run through the corner cases, then random requests under three idling
// patterns and one long result stall. The checker compares every result.
// ----------------------------------------------------------------------------
module top_k_min_heap_core_tb;
    import tkmh_pkg::*;

    localparam logic [PADDR_W-1:0] HEAP_SIZE_ADDR = '0;
    localparam logic [1:0]         REQ_UNUSED     = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;
    int                     tx_gap_pct = 0;
    int                     rx_gap_pct = 0;
    int                     rx_hold = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    top_k_min_heap_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    top_k_min_heap_checker #(
        .P_HEAP_SIZE_ADDR (HEAP_SIZE_ADDR)
    ) heap_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // The result side stalls at random, or for a whole stretch while rx_hold runs down.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_request(input logic [1:0] req, input logic [DATA_W-1:0] id,
                                input logic [DATA_W-1:0] score);
        if ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {score, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic random_request();
        logic [1:0]        req;
        logic [DATA_W-1:0] score;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            req = REQ_OFFER;
        end else if (pick < 93) begin
            req = REQ_DUMP;
        end else if (pick < 98) begin
            req = REQ_CLEAR;
        end else begin
            req = REQ_UNUSED;
        end
        case ($urandom_range(3))
            0, 1: score = $urandom;
            2: score = $urandom_range(15);
            default: score = 32'hFFFF_FFFF - $urandom_range(15);
        endcase
        push_request(req, $urandom, score);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Leave the core quiet before the next register access.
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= HEAP_SIZE_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_heap_size(input logic [PDATA_W-1:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct,
                                input logic [PDATA_W-1:0] k, input int count,
                                input int hold);
        wait_idle();
        set_heap_size(k);
        tx_gap_pct = tx_pct;
        rx_gap_pct = rx_pct;
        rx_hold    = hold;
        repeat (count) random_request();
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(1'b0, '0);

        push_request(REQ_DUMP, '0, '0);
        push_request(REQ_CLEAR, '0, '0);
        push_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(REQ_OFFER, 32'h0000_0000, 32'h8000_0000);
        push_request(REQ_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(REQ_OFFER, 32'h0000_0001, 32'h0000_0000);
        push_request(REQ_OFFER, 32'h0000_0002, 32'h0000_0000);
        push_request(REQ_OFFER, 32'h0000_0003, 32'h8000_0000);
        push_request(REQ_OFFER, 32'h0000_0004, 32'h0000_0005);
        push_request(REQ_DUMP, '0, '0);
        push_request(REQ_UNUSED, '0, '0);
        wait_idle();

        // Lowering k below the held count keeps only the front of the array.
        set_heap_size(32'd3);
        push_request(REQ_DUMP, '0, '0);
        push_request(REQ_OFFER, 32'h0000_0010, 32'h0000_0000);
        push_request(REQ_OFFER, 32'h0000_0011, 32'h8000_0000);
        push_request(REQ_OFFER, 32'h0000_0012, 32'h0000_0001);
        push_request(REQ_OFFER, 32'h0000_0013, 32'hFFFF_FFFF);
        push_request(REQ_DUMP, '0, '0);
        push_request(REQ_CLEAR, '0, '0);
        push_request(REQ_DUMP, '0, '0);
        push_request(REQ_OFFER, 32'h0000_0020, 32'd9);
        push_request(REQ_OFFER, 32'h0000_0021, 32'd9);
        push_request(REQ_OFFER, 32'h0000_0022, 32'd9);
        push_request(REQ_OFFER, 32'h0000_0023, 32'd9);
        push_request(REQ_OFFER, 32'h0000_0024, 32'd10);
        push_request(REQ_DUMP, '0, '0);

        random_phase(30, 80, 32'hFFFF_FF86, 25, 0);
        random_phase(80, 30, 32'd0, 20, 0);
        random_phase(0, 0, 32'd127, 30, 300);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
